[hdl/gpsc_pkg.sv]
// Package for the gamepad prompt source classifier.
// Holds the poll and result transfer types, config codes, reset values and the config bundle.
// No dependencies.
package gpsc_pkg;

    // command codes of a poll item
    localparam logic [1:0] CMD_POLL     = 2'd0;
    localparam logic [1:0] CMD_RESET    = 2'd1;
    localparam logic [1:0] CMD_KBM_NOTE = 2'd2;

    // config register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_DZ      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_DZ     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIG_THRESH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STICK_RESEL  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIG_RESEL   = 3'd4;
    localparam int CFG_DATA_W = 16;

    // reset values
    localparam int LEFT_DZ_RESET      = 7849;
    localparam int RIGHT_DZ_RESET     = 8689;
    localparam int TRIG_THRESH_RESET  = 30;
    localparam int STICK_RESEL_RESET  = 6000;
    localparam int TRIG_RESEL_RESET   = 30;

    localparam logic [29:0] LEFT_DZ_SQ_RESET     = 30'(LEFT_DZ_RESET * LEFT_DZ_RESET);
    localparam logic [29:0] RIGHT_DZ_SQ_RESET    = 30'(RIGHT_DZ_RESET * RIGHT_DZ_RESET);
    localparam logic [31:0] STICK_RESEL_SQ_RESET = 32'(STICK_RESEL_RESET * STICK_RESEL_RESET);

    // one poll of the primary pad
    typedef struct packed {
        logic [1:0]         command;
        logic               connected;
        logic               kbm_active;
        logic [15:0]        buttons;
        logic [7:0]         left_trigger;
        logic [7:0]         right_trigger;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
    } poll_t;

    // one result of a poll
    typedef struct packed {
        logic prompt_source;
        logic edge_seen;
        logic slot_selecting;
    } result_t;

    // config as the decision logic sees it, radii kept squared
    typedef struct packed {
        logic [29:0] left_dz_sq;
        logic [29:0] right_dz_sq;
        logic [7:0]  trig_thresh;
        logic [31:0] stick_resel_sq;
        logic [7:0]  trig_resel;
    } cfg_t;

endpackage

[hdl/gpsc_cfg.sv]
// Config register file for the prompt source classifier.
// Squares the radius registers as they are written. Depends on gpsc_pkg.
module gpsc_cfg
    import gpsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t        cfg_reg;
    logic [31:0] data_sq;

    // one square per write, registered with the value
    assign data_sq   = 32'(cfg_data) * 32'(cfg_data);
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_dz_sq     <= LEFT_DZ_SQ_RESET;
            cfg_reg.right_dz_sq    <= RIGHT_DZ_SQ_RESET;
            cfg_reg.trig_thresh    <= 8'(TRIG_THRESH_RESET);
            cfg_reg.stick_resel_sq <= STICK_RESEL_SQ_RESET;
            cfg_reg.trig_resel     <= 8'(TRIG_RESEL_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LEFT_DZ:     cfg_reg.left_dz_sq     <= 30'(32'(cfg_data[14:0]) *
                                                               32'(cfg_data[14:0]));
                CFG_RIGHT_DZ:    cfg_reg.right_dz_sq    <= 30'(32'(cfg_data[14:0]) *
                                                               32'(cfg_data[14:0]));
                CFG_TRIG_THRESH: cfg_reg.trig_thresh    <= cfg_data[7:0];
                CFG_STICK_RESEL: cfg_reg.stick_resel_sq <= data_sq;
                CFG_TRIG_RESEL:  cfg_reg.trig_resel     <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

endmodule

[hdl/gpsc_core.sv]
// Decision logic and prompt state of the prompt source classifier.
// Evaluates one poll per cycle while fire is high and updates the anchor and source state. Depends on gpsc_pkg.
module gpsc_core
    import gpsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  poll_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    // state
    logic [15:0]        prev_buttons_reg, prev_buttons_next;
    logic               baseline_valid_reg, baseline_valid_next;
    logic               anchor_valid_reg, anchor_valid_next;
    logic signed [15:0] anchor_lx_reg, anchor_ly_reg, anchor_rx_reg, anchor_ry_reg;
    logic [31:0]        anchor_lsq_reg, anchor_rsq_reg;
    logic [7:0]         anchor_lt_reg, anchor_rt_reg;
    logic               prompt_src_reg, prompt_src_next;
    logic               selecting_reg, selecting_next;
    logic               capture;

    // squared radii of the current sticks
    logic signed [31:0] lx2, ly2, rx2, ry2;
    logic [31:0]        lsq, rsq;
    assign lx2 = item.left_x * item.left_x;
    assign ly2 = item.left_y * item.left_y;
    assign rx2 = item.right_x * item.right_x;
    assign ry2 = item.right_y * item.right_y;
    assign lsq = $unsigned(lx2) + $unsigned(ly2);
    assign rsq = $unsigned(rx2) + $unsigned(ry2);

    // squared distance from the anchor
    logic signed [16:0] ldx, ldy, rdx, rdy;
    logic signed [33:0] ldx2, ldy2, rdx2, rdy2;
    logic [33:0]        ldist, rdist;
    assign ldx  = $signed({item.left_x[15], item.left_x})   - $signed({anchor_lx_reg[15], anchor_lx_reg});
    assign ldy  = $signed({item.left_y[15], item.left_y})   - $signed({anchor_ly_reg[15], anchor_ly_reg});
    assign rdx  = $signed({item.right_x[15], item.right_x}) - $signed({anchor_rx_reg[15], anchor_rx_reg});
    assign rdy  = $signed({item.right_y[15], item.right_y}) - $signed({anchor_ry_reg[15], anchor_ry_reg});
    assign ldx2 = ldx * ldx;
    assign ldy2 = ldy * ldy;
    assign rdx2 = rdx * rdx;
    assign rdy2 = rdy * rdy;
    assign ldist = {1'b0, ldx2[32:0]} + {1'b0, ldy2[32:0]};
    assign rdist = {1'b0, rdx2[32:0]} + {1'b0, rdy2[32:0]};

    // activity of the current poll and of the anchor
    logic left_now, right_now, lt_now, rt_now, any_now;
    logic left_anc, right_anc, lt_anc, rt_anc;
    logic left_far, right_far;
    logic [7:0] lt_diff, rt_diff;
    assign left_now  = lsq > {2'b00, cfg.left_dz_sq};
    assign right_now = rsq > {2'b00, cfg.right_dz_sq};
    assign lt_now    = item.left_trigger > cfg.trig_thresh;
    assign rt_now    = item.right_trigger > cfg.trig_thresh;
    assign any_now   = left_now || right_now || lt_now || rt_now;
    assign left_anc  = anchor_lsq_reg > {2'b00, cfg.left_dz_sq};
    assign right_anc = anchor_rsq_reg > {2'b00, cfg.right_dz_sq};
    assign lt_anc    = anchor_lt_reg > cfg.trig_thresh;
    assign rt_anc    = anchor_rt_reg > cfg.trig_thresh;
    assign left_far  = ldist > {2'b00, cfg.stick_resel_sq};
    assign right_far = rdist > {2'b00, cfg.stick_resel_sq};
    assign lt_diff   = (item.left_trigger > anchor_lt_reg) ? item.left_trigger - anchor_lt_reg
                                                          : anchor_lt_reg - item.left_trigger;
    assign rt_diff   = (item.right_trigger > anchor_rt_reg) ? item.right_trigger - anchor_rt_reg
                                                           : anchor_rt_reg - item.right_trigger;

    // edges of the current poll
    logic button_edge, analog, fresh, edge_found, live_poll;
    assign live_poll   = (item.command == CMD_POLL) && item.connected;
    assign fresh       = !baseline_valid_reg || !anchor_valid_reg;
    assign button_edge = baseline_valid_reg ? |(item.buttons & ~prev_buttons_reg)
                                            : |item.buttons;
    assign analog      = fresh ? any_now
                       : ((left_now && (!left_anc || left_far)) ||
                          (right_now && (!right_anc || right_far)) ||
                          (lt_now && (!lt_anc || lt_diff >= cfg.trig_resel)) ||
                          (rt_now && (!rt_anc || rt_diff >= cfg.trig_resel)));
    assign edge_found  = live_poll && (button_edge || analog);

    // next state per command
    always_comb
    begin
        prev_buttons_next   = prev_buttons_reg;
        baseline_valid_next = baseline_valid_reg;
        anchor_valid_next   = anchor_valid_reg;
        prompt_src_next     = prompt_src_reg;
        selecting_next      = selecting_reg;
        capture             = 1'b0;
        case (item.command)
            CMD_RESET:
            begin
                prompt_src_next     = 1'b0;
                prev_buttons_next   = '0;
                baseline_valid_next = 1'b0;
                anchor_valid_next   = 1'b0;
                selecting_next      = 1'b0;
            end
            CMD_KBM_NOTE:
            begin
                prompt_src_next = 1'b0;
            end
            CMD_POLL:
            begin
                if (!item.connected)
                begin
                    prev_buttons_next   = '0;
                    baseline_valid_next = 1'b0;
                    anchor_valid_next   = 1'b0;
                    selecting_next      = 1'b0;
                    prompt_src_next     = 1'b0;
                end
                else
                begin
                    prev_buttons_next   = item.buttons;
                    baseline_valid_next = 1'b1;
                    capture             = fresh || analog || !any_now;
                    if (item.kbm_active)
                    begin
                        prompt_src_next = 1'b0;
                        selecting_next  = 1'b0;
                        capture         = 1'b1;
                    end
                    else if (edge_found)
                    begin
                        prompt_src_next = 1'b1;
                        selecting_next  = 1'b1;
                        capture         = 1'b1;
                    end
                    if (capture)
                    begin
                        anchor_valid_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // result of this poll
    assign result.prompt_source  = prompt_src_next;
    assign result.edge_seen      = edge_found;
    assign result.slot_selecting = selecting_next;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_buttons_reg   <= '0;
            baseline_valid_reg <= 1'b0;
            anchor_valid_reg   <= 1'b0;
            prompt_src_reg     <= 1'b0;
            selecting_reg      <= 1'b0;
            anchor_lx_reg      <= '0;
            anchor_ly_reg      <= '0;
            anchor_rx_reg      <= '0;
            anchor_ry_reg      <= '0;
            anchor_lsq_reg     <= '0;
            anchor_rsq_reg     <= '0;
            anchor_lt_reg      <= '0;
            anchor_rt_reg      <= '0;
        end
        else if (fire)
        begin
            prev_buttons_reg   <= prev_buttons_next;
            baseline_valid_reg <= baseline_valid_next;
            anchor_valid_reg   <= anchor_valid_next;
            prompt_src_reg     <= prompt_src_next;
            selecting_reg      <= selecting_next;
            // anchor capture keeps the squared radius for later checks
            if (capture)
            begin
                anchor_lx_reg  <= item.left_x;
                anchor_ly_reg  <= item.left_y;
                anchor_rx_reg  <= item.right_x;
                anchor_ry_reg  <= item.right_y;
                anchor_lsq_reg <= lsq;
                anchor_rsq_reg <= rsq;
                anchor_lt_reg  <= item.left_trigger;
                anchor_rt_reg  <= item.right_trigger;
            end
        end
    end

    // controller prompts are only shown while the slot is selecting
    a_src_implies_sel: assert property (@(posedge clk) disable iff (!rst_n)
        prompt_src_reg |-> selecting_reg)
        else $error("controller source without slot selection");

    // selection needs a button baseline
    a_sel_implies_base: assert property (@(posedge clk) disable iff (!rst_n)
        selecting_reg |-> baseline_valid_reg)
        else $error("slot selecting without baseline");

    // a reset command drops anchor and selection
    a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.command == CMD_RESET) |=> (!anchor_valid_reg && !selecting_reg))
        else $error("reset command left anchor or selection");

endmodule

[hdl/gamepad_prompt_source_classifier.sv]
// Path: a poll accepted into the poll register has its result registered in the result register.
// Throughput: one poll per cycle; while a result waits, the poll register still takes
// one more transfer, and the poll channel stalls only once both registers are full.
// Reset: asynchronous, active low; keyboard/mouse prompts, no selection, no anchor,
// config registers back to their reset values.
module gamepad_prompt_source_classifier
    import gpsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   poll_valid,
    output logic                   poll_ready,
    input  poll_t                  poll,
    output logic                   result_valid,
    input  logic                   result_ready,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    poll_t   poll_reg;
    logic    poll_valid_reg;
    result_t result_reg, core_result;
    logic    result_valid_reg;
    logic    advance;

    gpsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gpsc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (poll_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // stage moves when the result slot is free or being emptied
    assign advance      = poll_valid_reg && (!result_valid_reg || result_ready);
    assign poll_ready   = !poll_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // poll register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg <= 1'b0;
        end
        else if (poll_valid && poll_ready)
        begin
            poll_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            poll_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_valid && poll_ready)
        begin
            poll_reg <= poll;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    // a poll that leaves the first stage always lands in the result slot
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("processed poll lost before result register");

    // back pressure only comes from a held poll
    a_stall_has_poll: assert property (@(posedge clk) disable iff (!rst_n)
        !poll_ready |-> (poll_valid_reg && result_valid_reg && !result_ready))
        else $error("poll channel stalled without cause");

    // a waiting result stays put until its transfer
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_ready) |=> (result_valid_reg && $stable(result_reg)))
        else $error("waiting result changed before transfer");

endmodule

[sim/tb_gamepad_prompt_source_classifier.sv]
// Testbench for the gamepad prompt source classifier: a directed table, then random
// pad sessions under several register settings, every result checked in order.
// Depends on gpsc_pkg and the gamepad_prompt_source_classifier module only.
module tb_gamepad_prompt_source_classifier;
    import gpsc_pkg::*;

    // command code the block must ignore, and a register index that maps to nothing
    localparam logic [1:0]             CMD_UNUSED  = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOWHERE = 3'd5;
    localparam int PHASES      = 8;
    localparam int PHASE_POLLS = 172;
    localparam int IDLE_PCT    = 13;
    localparam int PRINT_CAP   = 20;

    typedef struct {
        poll_t   p;
        bit      typed;
        result_t want;
    } row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   poll_valid = 1'b0;
    logic                   poll_ready;
    poll_t                  poll = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // register mirror
    logic [14:0] dz_left    = 15'(LEFT_DZ_RESET);
    logic [14:0] dz_right   = 15'(RIGHT_DZ_RESET);
    logic [7:0]  trig_on    = 8'(TRIG_THRESH_RESET);
    logic [15:0] stick_move = 16'(STICK_RESEL_RESET);
    logic [7:0]  trig_move  = 8'(TRIG_RESEL_RESET);

    // prompt state mirror
    logic [15:0]        seen_buttons = '0;
    bit                 have_baseline = 1'b0;
    bit                 have_anchor = 1'b0;
    logic signed [15:0] anchor_stick [4] = '{default: '0};
    logic [7:0]         anchor_trig [2] = '{default: '0};
    logic               shown_source = 1'b0;
    logic               holds_selection = 1'b0;

    // pad that the random sessions play on
    logic [15:0]        pad_buttons = '0;
    logic [7:0]         pad_trig [2] = '{default: '0};
    logic signed [15:0] pad_stick [4] = '{default: '0};

    result_t pending_results [$];
    row_t    steer [$];
    bit      calm = 1'b0;
    int      mismatches = 0;
    int      polls_sent = 0;
    int      edges_predicted = 0;
    int      settings_used = 1;

    gamepad_prompt_source_classifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_valid   (poll_valid),
        .poll_ready   (poll_ready),
        .poll         (poll),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic poll_t mk(input logic [1:0] cmd, input int conn, input int kbm,
                                 input logic [15:0] btn, input int lt,
                                 input int rt, input int lx, input int ly,
                                 input int rx, input int ry);
        poll_t p;
        p.command       = cmd;
        p.connected     = 1'(conn);
        p.kbm_active    = 1'(kbm);
        p.buttons       = btn;
        p.left_trigger  = 8'(lt);
        p.right_trigger = 8'(rt);
        p.left_x        = 16'(lx);
        p.left_y        = 16'(ly);
        p.right_x       = 16'(rx);
        p.right_y       = 16'(ry);
        return p;
    endfunction

    // squared radius against squared limit, wide enough for the extremes
    function automatic bit outside_radius(input logic signed [15:0] x, input logic signed [15:0] y,
                                          input logic [15:0] rad);
        longint sx, sy, sr;
        sx = x;
        sy = y;
        sr = rad;
        return sx * sx + sy * sy > sr * sr;
    endfunction

    function automatic bit moved_far(input logic signed [15:0] ax, input logic signed [15:0] ay,
                                     input logic signed [15:0] bx, input logic signed [15:0] by);
        longint dx, dy, lim;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        lim = stick_move;
        return dx * dx + dy * dy > lim * lim;
    endfunction

    function automatic int trig_gap(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    // prompt decision for one poll, updates the state mirror
    task automatic classify_poll(input poll_t p, output result_t r);
        bit left_now, right_now, lt_now, rt_now;
        bit btn_edge, analog, capture, edge_hit;
        edge_hit = 1'b0;
        if (p.command == CMD_RESET || (p.command == CMD_POLL && !p.connected))
        begin
            shown_source    = 1'b0;
            holds_selection = 1'b0;
            seen_buttons    = '0;
            have_baseline   = 1'b0;
            have_anchor     = 1'b0;
        end
        else if (p.command == CMD_KBM_NOTE)
        begin
            shown_source = 1'b0;
        end
        else if (p.command == CMD_POLL)
        begin
            left_now  = outside_radius(p.left_x, p.left_y, dz_left);
            right_now = outside_radius(p.right_x, p.right_y, dz_right);
            lt_now    = p.left_trigger > trig_on;
            rt_now    = p.right_trigger > trig_on;
            btn_edge  = have_baseline ? ((p.buttons & ~seen_buttons) != '0) : (p.buttons != '0);
            analog    = 1'b0;
            capture   = 1'b0;
            if (!have_baseline || !have_anchor)
            begin
                analog  = left_now || right_now || lt_now || rt_now;
                capture = 1'b1;
            end
            else
            begin
                if (left_now)
                    analog = !outside_radius(anchor_stick[0], anchor_stick[1], dz_left) ||
                             moved_far(p.left_x, p.left_y, anchor_stick[0], anchor_stick[1]);
                if (!analog && right_now)
                    analog = !outside_radius(anchor_stick[2], anchor_stick[3], dz_right) ||
                             moved_far(p.right_x, p.right_y, anchor_stick[2], anchor_stick[3]);
                if (!analog && lt_now)
                    analog = !(anchor_trig[0] > trig_on) ||
                             trig_gap(p.left_trigger, anchor_trig[0]) >= int'(trig_move);
                if (!analog && rt_now)
                    analog = !(anchor_trig[1] > trig_on) ||
                             trig_gap(p.right_trigger, anchor_trig[1]) >= int'(trig_move);
                if (analog || !(left_now || right_now || lt_now || rt_now))
                    capture = 1'b1;
            end
            edge_hit      = btn_edge || analog;
            seen_buttons  = p.buttons;
            have_baseline = 1'b1;
            // keyboard activity wins over a pad edge
            if (p.kbm_active)
            begin
                shown_source    = 1'b0;
                holds_selection = 1'b0;
                capture         = 1'b1;
            end
            else if (edge_hit)
            begin
                shown_source    = 1'b1;
                holds_selection = 1'b1;
                capture         = 1'b1;
            end
            if (capture)
            begin
                anchor_stick[0] = p.left_x;
                anchor_stick[1] = p.left_y;
                anchor_stick[2] = p.right_x;
                anchor_stick[3] = p.right_y;
                anchor_trig[0]  = p.left_trigger;
                anchor_trig[1]  = p.right_trigger;
                have_anchor     = 1'b1;
            end
        end
        if (edge_hit)
            edges_predicted++;
        r.prompt_source  = shown_source;
        r.edge_seen      = edge_hit;
        r.slot_selecting = holds_selection;
    endtask

    // next position of one stick axis: center, hold, drift, jump, rail, or graze the deadzone
    function automatic logic signed [15:0] wiggle_axis(input logic signed [15:0] v,
                                                       input int rim);
        int n;
        case ($urandom_range(0, 9))
            0: n = 0;
            1: n = int'($urandom_range(0, 4000)) - 2000;
            2, 3, 4: n = v;
            5, 6: n = int'(v) + int'($urandom_range(0, 16000)) - 8000;
            7: n = int'($urandom_range(0, 65535)) - 32768;
            8: n = $urandom_range(0, 1) ? 32767 : -32768;
            default:
            begin
                n = rim + int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1))
                    n = -n;
            end
        endcase
        if (n > 32767)
            n = 32767;
        if (n < -32768)
            n = -32768;
        return 16'(n);
    endfunction

    function automatic logic [7:0] wiggle_trigger(input logic [7:0] v);
        int n;
        case ($urandom_range(0, 7))
            0: n = 0;
            1, 2, 3: n = v;
            4: n = int'(v) + int'($urandom_range(0, 80)) - 40;
            5: n = $urandom_range(0, 255);
            6: n = 255;
            default: n = int'(trig_on) + int'($urandom_range(0, 4)) - 2;
        endcase
        if (n > 255)
            n = 255;
        if (n < 0)
            n = 0;
        return 8'(n);
    endfunction

    // mostly connected polls of an evolving pad, with commands and dropouts mixed in
    function automatic poll_t gen_poll();
        poll_t p;
        int    pick;
        pick = $urandom_range(0, 99);
        p = mk(CMD_POLL, 1, 0, 16'($urandom), int'($urandom_range(0, 255)),
               int'($urandom_range(0, 255)), $urandom, $urandom, $urandom, $urandom);
        if (pick < 3)
            p.command = CMD_RESET;
        else if (pick < 6)
            p.command = CMD_KBM_NOTE;
        else if (pick < 8)
            p.command = CMD_UNUSED;
        else if (pick < 12)
            p.connected = 1'b0;
        if (pick < 12)
        begin
            p.kbm_active = 1'($urandom);
            if (p.command != CMD_POLL)
                p.connected = 1'($urandom);
            return p;
        end
        // button moves: hold, press or release one, scramble, all or none
        case ($urandom_range(0, 7))
            0: pad_buttons = '0;
            1, 2, 3: ;
            4, 5: pad_buttons[$urandom_range(0, 15)] ^= 1'b1;
            6: pad_buttons = 16'($urandom);
            default: pad_buttons = 16'hFFFF;
        endcase
        if ($urandom_range(0, 7) == 0)
        begin
            pad_stick = '{default: '0};
            pad_trig  = '{default: '0};
        end
        else
        begin
            pad_stick[0] = wiggle_axis(pad_stick[0], int'(dz_left));
            pad_stick[1] = wiggle_axis(pad_stick[1], int'(dz_left));
            pad_stick[2] = wiggle_axis(pad_stick[2], int'(dz_right));
            pad_stick[3] = wiggle_axis(pad_stick[3], int'(dz_right));
            pad_trig[0]  = wiggle_trigger(pad_trig[0]);
            pad_trig[1]  = wiggle_trigger(pad_trig[1]);
        end
        p.kbm_active    = ($urandom_range(0, 9) == 0);
        p.buttons       = pad_buttons;
        p.left_trigger  = pad_trig[0];
        p.right_trigger = pad_trig[1];
        p.left_x        = pad_stick[0];
        p.left_y        = pad_stick[1];
        p.right_x       = pad_stick[2];
        p.right_y       = pad_stick[3];
        return p;
    endfunction

    // one poll transfer; called at a rising edge
    task automatic send_poll(input poll_t p, input bit typed, input result_t want);
        result_t guess;
        poll       <= p;
        poll_valid <= 1'b1;
        do
            @(posedge clk);
        while (!poll_ready);
        classify_poll(p, guess);
        pending_results.push_back(typed ? want : guess);
        polls_sent++;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            poll_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // one register transfer; called at a rising edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_LEFT_DZ:     dz_left    = data[14:0];
            CFG_RIGHT_DZ:    dz_right   = data[14:0];
            CFG_TRIG_THRESH: trig_on    = data[7:0];
            CFG_STICK_RESEL: stick_move = data;
            CFG_TRIG_RESEL:  trig_move  = data[7:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and let every result come back
    task automatic settle();
        poll_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // result sink: check each transfer, stall at random
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                    flag_mismatch($sformatf("result %b with nothing pending", result));
                else
                begin
                    want = pending_results.pop_front();
                    if (result.prompt_source !== want.prompt_source)
                        flag_mismatch($sformatf("prompt_source %b, want %b",
                                                result.prompt_source, want.prompt_source));
                    if (result.edge_seen !== want.edge_seen)
                        flag_mismatch($sformatf("edge_seen %b, want %b",
                                                result.edge_seen, want.edge_seen));
                    if (result.slot_selecting !== want.slot_selecting)
                        flag_mismatch($sformatf("slot_selecting %b, want %b",
                                                result.slot_selecting, want.slot_selecting));
                end
            end
            result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // stimulus
    initial
    begin
        logic [15:0] lz, rz, th, sm, tm;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under reset settings; typed rows are {source, edge, selecting}
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'h0000, 0, 0, 0, 0, 0, 0), 1'b1, 3'b000});
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0), 1'b1, 3'b111});
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0), 1'b1, 3'b101});
        steer.push_back('{mk(CMD_KBM_NOTE, 1, 1, 16'hFFFF, 255, 255, -1, -1, -1, -1),
                          1'b1, 3'b001});
        steer.push_back('{mk(CMD_UNUSED, 0, 1, 16'hFFFF, 255, 255, -32768, 32767, 0, 0),
                          1'b1, 3'b001});
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'h0000, 255, 255, -32768, -32768, 32767, 32767),
                          1'b0, '0});
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'h0000, 255, 255, -32768, -32768, 32767, 32767),
                          1'b0, '0});
        steer.push_back('{mk(CMD_POLL, 1, 1, 16'h0001, 0, 0, 0, 0, 0, 0), 1'b1, 3'b010});
        steer.push_back('{mk(CMD_POLL, 0, 1, 16'hFFFF, 255, 255, 32767, 32767, -32768, -32768),
                          1'b1, 3'b000});
        steer.push_back('{mk(CMD_RESET, 1, 1, 16'hFFFF, 255, 255, 100, 100, 100, 100),
                          1'b1, 3'b000});
        // trigger just over and at the threshold
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'h0000, 31, 0, 0, 0, 0, 0), 1'b0, '0});
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'h0000, 30, 0, 0, 0, 0, 0), 1'b0, '0});
        // stick on the deadzone rim, then just past it
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'h0000, 0, 0, 7849, 0, 0, 0), 1'b0, '0});
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'h0000, 0, 0, 7850, 0, 0, 0), 1'b0, '0});
        // moves of exactly and just over the reselect distance
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'h0000, 0, 0, 7850, 6000, 0, 0), 1'b0, '0});
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'h0000, 0, 0, 7850, 6001, 0, 0), 1'b0, '0});
        // trigger drift just under and at the reselect step
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'h0000, 0, 100, 0, 0, 0, 0), 1'b0, '0});
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'h0000, 0, 129, 0, 0, 0, 0), 1'b0, '0});
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'h0000, 0, 130, 0, 0, 0, 0), 1'b0, '0});
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'h8000, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'h8000, 0, 0, 0, 0, -32768, 0), 1'b0, '0});
        steer.push_back('{mk(CMD_POLL, 1, 0, 16'h0000, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        steer.push_back('{mk(CMD_POLL, 1, 1, 16'h0000, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        foreach (steer[i])
            send_poll(steer[i].p, steer[i].typed, steer[i].want);
        settle();

        // random sessions, one register setting per phase
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    lz = 16'hFFFF; rz = 16'h7FFF; th = 16'h00FF; sm = 16'hFFFF; tm = 16'hFFFF;
                    write_reg(CFG_NOWHERE, 16'($urandom));
                end
                1:
                begin
                    lz = 16'h8000; rz = 16'h0000; th = 16'hFF00; sm = 16'h0000; tm = 16'h0000;
                end
                2:
                begin
                    lz = 16'(LEFT_DZ_RESET); rz = 16'(RIGHT_DZ_RESET);
                    th = 16'(TRIG_THRESH_RESET); sm = 16'(STICK_RESEL_RESET);
                    tm = 16'(TRIG_RESEL_RESET);
                end
                default:
                begin
                    lz = {1'($urandom), 15'($urandom_range(0, 16000))};
                    rz = {1'($urandom), 15'($urandom_range(0, 16000))};
                    th = {8'($urandom), 8'($urandom_range(0, 255))};
                    sm = 16'($urandom_range(0, 20000));
                    tm = {8'($urandom), 8'($urandom_range(0, 80))};
                end
            endcase
            write_reg(CFG_LEFT_DZ, lz);
            write_reg(CFG_RIGHT_DZ, rz);
            write_reg(CFG_TRIG_THRESH, th);
            write_reg(CFG_STICK_RESEL, sm);
            write_reg(CFG_TRIG_RESEL, tm);
            settings_used++;
            // one phase runs with both sides always ready
            calm = (ph == 2);
            repeat (PHASE_POLLS)
                send_poll(gen_poll(), 1'b0, '0);
            settle();
            calm = 1'b0;
        end

        $display("covered %0d polls under %0d register settings, %0d predicted edges",
                 polls_sent, settings_used, edges_predicted);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
hdl/gpsc_pkg.sv
hdl/gpsc_cfg.sv
hdl/gpsc_core.sv
hdl/gamepad_prompt_source_classifier.sv
sim/tb_gamepad_prompt_source_classifier.sv
